/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the auto-framing RTL.
// No dependencies; included by each file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/afra_pkg.sv */
// Package for the auto-framing region accumulator: widths, register
// indexes, reset values, sequencer states, fit classes and divider status type.
// No dependencies.
`default_nettype none

package afra_pkg;

  localparam int unsigned COORD_BITS_DEF = 13;
  localparam int unsigned DIM_W          = 12;
  localparam int unsigned Q_FRAC         = 8;   // fraction bits of the refitted size

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_W_RST = 12'd640;
  localparam logic [DIM_W-1:0] FRAME_H_RST = 12'd480;

  // serial divider: 32-bit dividend, 12-bit divisor, two quotient bits a cycle
  localparam int unsigned DIV_W            = 32;
  localparam int unsigned DIV_BITS_PER_CYC = 2;
  localparam int unsigned DIV_CYCLES       = DIV_W / DIV_BITS_PER_CYC;
  localparam int unsigned DIV_CNT_W        = $clog2(DIV_CYCLES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNION,
    ST_SPAN,
    ST_MUL_A,
    ST_MUL_B,
    ST_CLASS,
    ST_DIV1,
    ST_MUL_T,
    ST_DIV2,
    ST_POS1,
    ST_POS2,
    ST_CLAMP,
    ST_DONE
  } state_e;

  // FIT_CAP: too tall, width capped at 2.5x; FIT_TALL: width grown from
  // height; FIT_WIDE: height grown from width
  typedef enum logic [1:0] {
    FIT_CAP,
    FIT_TALL,
    FIT_WIDE
  } fit_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/afra_div.sv */
// Restoring unsigned divider, 32-bit dividend by 12-bit divisor, radix 4.
// Depends on afra_pkg and assert_macros.svh. A zero divisor gives zero.
`default_nettype none
`include "assert_macros.svh"

module afra_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [afra_pkg::DIV_W-1:0]    dividend_i,
  input  logic [afra_pkg::DIM_W-1:0]    divisor_i,
  output logic [afra_pkg::DIV_W-1:0]    quotient_o,
  output afra_pkg::div_stat_t           stat_o
);

  logic [afra_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [afra_pkg::DIM_W-1:0]     rem_q, rem_d;
  logic [afra_pkg::DIM_W-1:0]     den_q;
  logic [afra_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;

  // dividend shifts out of the top of quo_q as quotient bits enter below
  always_comb begin : div_step
    logic [afra_pkg::DIM_W:0]   trial;
    logic [afra_pkg::DIM_W-1:0] r;
    logic [afra_pkg::DIV_W-1:0] q;
    r     = rem_q;
    q     = quo_q;
    trial = '0;
    for (int i = 0; i < afra_pkg::DIV_BITS_PER_CYC; i++) begin
      trial = {r, q[afra_pkg::DIV_W-1]};
      q     = {q[afra_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        q[0]  = 1'b1;
      end
      r = trial[afra_pkg::DIM_W-1:0];
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= (divisor_i != '0);
        done_q <= (divisor_i == '0);
        cnt_q  <= afra_pkg::DIV_CNT_W'(afra_pkg::DIV_CYCLES - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= (divisor_i == '0) ? '0 : dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `ASSERT_IMPLIES(a_start_when_free, clk_i, rst_ni, start_i, !busy_q, "divider restarted while busy")
  `ASSERT_NEXT(a_last_step_done, clk_i, rst_ni, busy_q && !start_i && cnt_q == '0, done_q && !busy_q, "divider missed its done pulse")
  `ASSERT_NEXT(a_zero_divisor, clk_i, rst_ni, start_i && divisor_i == '0, done_q && quotient_o == '0, "zero divisor not short-cut")

endmodule

`default_nettype wire

/* hw/rtl/auto_frame_region_accumulate_top.sv */
// Auto-framing region accumulator: unions each detection box into the region and refits it.
// One box at a time: union, span, two products, aspect class, a first divide (skipped when
// the 2.5x cap applies), the refit product, a second divide, placement and clamp.
// The next box is taken while a result waits in the output register.
// Reset (async, active low): frame 640x480, region (640, 480, -640, -480), no result pending.
// Depends on afra_pkg, afra_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module auto_frame_region_accumulate_top #(
  parameter int unsigned COORD_BITS = afra_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [afra_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [afra_pkg::DIM_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_BITS-1:0]        box_left_i,
  input  logic signed [COORD_BITS-1:0]        box_top_i,
  input  logic [afra_pkg::DIM_W-1:0]          box_width_i,
  input  logic [afra_pkg::DIM_W-1:0]          box_height_i,
  input  logic                                first_box_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [COORD_BITS:0]          region_left_o,
  output logic signed [COORD_BITS:0]          region_top_o,
  output logic signed [COORD_BITS:0]          region_width_o,
  output logic signed [COORD_BITS:0]          region_height_o
);

  localparam int unsigned DIM_W  = afra_pkg::DIM_W;
  localparam int unsigned QF     = afra_pkg::Q_FRAC;
  localparam int unsigned RW     = COORD_BITS + 1;  // region and state
  localparam int unsigned AW     = COORD_BITS + 5;  // union arithmetic
  localparam int unsigned UW     = AW - 1;          // union span, never negative
  localparam int unsigned PRW    = UW + DIM_W;      // span x frame dimension
  localparam int unsigned CW     = PRW + 3;         // aspect compare
  localparam int unsigned U5W    = UW + 3;
  localparam int unsigned QW     = DIM_W + QF;      // Q8 width and height
  localparam int unsigned NW     = AW + 2;          // region edges
  localparam int unsigned PW     = AW + 10;         // Q9 edge arithmetic

  localparam logic signed [DIM_W:0] FW_RST_S = $signed({1'b0, afra_pkg::FRAME_W_RST});
  localparam logic signed [DIM_W:0] FH_RST_S = $signed({1'b0, afra_pkg::FRAME_H_RST});

  afra_pkg::state_e    state_q, state_d;
  afra_pkg::fit_e      fit_q, fit_c;
  afra_pkg::div_stat_t div_stat;

  logic [DIM_W-1:0]           fw_q, fh_q;
  logic signed [RW-1:0]       cur_left_q, cur_top_q, cur_width_q, cur_height_q;
  logic signed [RW-1:0]       region_left_q, region_top_q, region_width_q, region_height_q;
  logic                       out_valid_q;

  logic signed [COORD_BITS-1:0] bx_q, by_q;
  logic [DIM_W-1:0]           bw_q, bh_q;
  logic signed [AW-1:0]       ul_q, ut_q, ur_q, ub_q, c_q;
  logic [UW-1:0]              u_q, v_q;
  logic [PRW-1:0]             prod_a_q, prod_b_q;
  logic [DIM_W-1:0]           t_q;
  logic [QW-1:0]              nw_q, nh_q;
  logic signed [NW-1:0]       nx0_q, nx1_q, ny0_q, ny1_q;

  logic                       in_acc, out_free, out_load;
  logic                       div_start;
  logic [afra_pkg::DIV_W-1:0] div_dividend, div_quotient;
  logic [DIM_W-1:0]           div_divisor;
  logic [UW-1:0]              mul_a;
  logic [DIM_W-1:0]           mul_b;
  logic [PRW-1:0]             mul_p;

  // ---------------------------------------------------------------- helpers
  logic signed [DIM_W:0]  fw_s, fh_s, fw_neg, fh_neg;
  assign fw_s   = $signed({1'b0, fw_q});
  assign fh_s   = $signed({1'b0, fh_q});
  assign fw_neg = -fw_s;
  assign fh_neg = -fh_s;

  // union
  logic signed [AW-1:0] bx_e, by_e, bw_e, bh_e, cl_e, ct_e, cw_e, ch_e;
  logic signed [AW-1:0] cur_r, cur_b, box_r, box_b, u_half;
  assign bx_e   = AW'(bx_q);
  assign by_e   = AW'(by_q);
  assign bw_e   = AW'(bw_q);
  assign bh_e   = AW'(bh_q);
  assign cl_e   = AW'(cur_left_q);
  assign ct_e   = AW'(cur_top_q);
  assign cw_e   = AW'(cur_width_q);
  assign ch_e   = AW'(cur_height_q);
  assign cur_r  = cl_e + cw_e;
  assign cur_b  = ct_e + ch_e;
  assign box_r  = bx_e + bw_e;
  assign box_b  = by_e + bh_e;
  assign u_half = AW'(u_q >> 1);

  // aspect classification: 2vW against 5uH, then vW against uH
  logic [CW-1:0]  fit_lhs, fit_rhs;
  logic [U5W-1:0] u5;
  logic [DIM_W-1:0] t_cap, t_lim, t_div;
  assign fit_lhs = {2'b00, prod_a_q, 1'b0};
  assign fit_rhs = {3'b000, prod_b_q} + {1'b0, prod_b_q, 2'b00};
  assign u5      = {3'b000, u_q} + {1'b0, u_q, 2'b00};
  assign t_cap   = (u5[U5W-1:1] > (U5W-1)'(fw_q)) ? fw_q : u5[DIM_W:1];
  assign t_lim   = (fit_q == afra_pkg::FIT_WIDE) ? fh_q : fw_q;
  assign t_div   = (div_quotient > afra_pkg::DIV_W'(t_lim)) ? t_lim
                                                          : div_quotient[DIM_W-1:0];

  always_comb begin
    if (fit_lhs > fit_rhs) begin
      fit_c = afra_pkg::FIT_CAP;
    end else if (prod_a_q > prod_b_q) begin
      fit_c = afra_pkg::FIT_TALL;
    end else begin
      fit_c = afra_pkg::FIT_WIDE;
    end
  end

  // placement in Q9 (centre) and Q8 (top); quotients truncate toward zero
  logic signed [PW-1:0] c9, nw_p, ut8, nh_p, nx0_p, nx0_off;
  logic signed [PW-1:0] x1, x1_b, x1_s, x1_t, z1, z1_b, z1_s, z1_t, y2, y2_b, y2_s, y2_t;
  assign c9      = PW'(c_q) <<< (QF + 1);
  assign nw_p    = PW'(nw_q);
  assign ut8     = PW'(ut_q) <<< QF;
  assign nh_p    = PW'(nh_q);
  assign nx0_p   = PW'(nx0_q);
  assign nx0_off = nx0_p <<< (QF + 1);

  assign x1   = c9 - nw_p;
  assign x1_b = {{(PW-QF-1){1'b0}}, {(QF+1){x1[PW-1]}}};
  assign x1_s = x1 + x1_b;
  assign x1_t = x1_s >>> (QF + 1);

  assign z1   = ut8 + nh_p;
  assign z1_b = {{(PW-QF){1'b0}}, {QF{z1[PW-1]}}};
  assign z1_s = z1 + z1_b;
  assign z1_t = z1_s >>> QF;

  assign y2   = c9 + nw_p - (nx0_q[NW-1] ? nx0_off : '0);
  assign y2_b = {{(PW-QF-1){1'b0}}, {(QF+1){y2[PW-1]}}};
  assign y2_s = y2 + y2_b;
  assign y2_t = y2_s >>> (QF + 1);

  logic signed [NW-1:0] fw_n, fh_n, ut_n;
  logic signed [RW-1:0] res_left, res_top, res_width, res_height;
  assign fw_n       = NW'(fw_q);
  assign fh_n       = NW'(fh_q);
  assign ut_n       = NW'(ut_q);
  assign res_left   = nx0_q[RW-1:0];
  assign res_top    = ny0_q[RW-1:0];
  assign res_width  = RW'(nx1_q - nx0_q);
  assign res_height = RW'(ny1_q - ny0_q);

  // shared multiplier
  assign mul_p = {{DIM_W{1'b0}}, mul_a} * {{UW{1'b0}}, mul_b};

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      afra_pkg::ST_IDLE:  if (in_acc) state_d = afra_pkg::ST_UNION;
      afra_pkg::ST_UNION: state_d = afra_pkg::ST_SPAN;
      afra_pkg::ST_SPAN:  state_d = afra_pkg::ST_MUL_A;
      afra_pkg::ST_MUL_A: state_d = afra_pkg::ST_MUL_B;
      afra_pkg::ST_MUL_B: state_d = afra_pkg::ST_CLASS;
      afra_pkg::ST_CLASS: begin
        state_d = (fit_c == afra_pkg::FIT_CAP) ? afra_pkg::ST_MUL_T : afra_pkg::ST_DIV1;
      end
      afra_pkg::ST_DIV1:  if (div_stat.done) state_d = afra_pkg::ST_MUL_T;
      afra_pkg::ST_MUL_T: state_d = afra_pkg::ST_DIV2;
      afra_pkg::ST_DIV2:  if (div_stat.done) state_d = afra_pkg::ST_POS1;
      afra_pkg::ST_POS1:  state_d = afra_pkg::ST_POS2;
      afra_pkg::ST_POS2:  state_d = afra_pkg::ST_CLAMP;
      afra_pkg::ST_CLAMP: state_d = afra_pkg::ST_DONE;
      afra_pkg::ST_DONE:  if (out_free) state_d = afra_pkg::ST_IDLE;
      default:            state_d = afra_pkg::ST_IDLE;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;

  always_comb begin
    in_stall_o   = 1'b1;
    out_load     = 1'b0;
    div_start    = 1'b0;
    div_dividend = afra_pkg::DIV_W'(prod_b_q);
    div_divisor  = fw_q;
    mul_a        = v_q;
    mul_b        = fw_q;
    case (state_q)
      afra_pkg::ST_IDLE: in_stall_o = 1'b0;
      afra_pkg::ST_MUL_A: begin
        mul_a = v_q;
        mul_b = fw_q;
      end
      afra_pkg::ST_MUL_B: begin
        mul_a = u_q;
        mul_b = fh_q;
      end
      afra_pkg::ST_CLASS: begin
        div_start = (fit_c != afra_pkg::FIT_CAP);
        if (fit_c == afra_pkg::FIT_TALL) begin
          div_dividend = afra_pkg::DIV_W'(prod_a_q);
          div_divisor  = fh_q;
        end else begin
          div_dividend = afra_pkg::DIV_W'(prod_b_q);
          div_divisor  = fw_q;
        end
      end
      afra_pkg::ST_MUL_T: begin
        // t x dimension in Q8 goes straight into the divider's registers
        div_start    = 1'b1;
        mul_a        = UW'(t_q);
        mul_b        = (fit_q == afra_pkg::FIT_WIDE) ? fw_q : fh_q;
        div_dividend = afra_pkg::DIV_W'({mul_p[2*DIM_W-1:0], {QF{1'b0}}});
        div_divisor  = (fit_q == afra_pkg::FIT_WIDE) ? fh_q : fw_q;
      end
      afra_pkg::ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= afra_pkg::ST_IDLE;
      fw_q         <= afra_pkg::FRAME_W_RST;
      fh_q         <= afra_pkg::FRAME_H_RST;
      cur_left_q   <= RW'(FW_RST_S);
      cur_top_q    <= RW'(FH_RST_S);
      cur_width_q  <= RW'(-FW_RST_S);
      cur_height_q <= RW'(-FH_RST_S);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          afra_pkg::REG_FRAME_W: fw_q <= cfg_data_i;
          afra_pkg::REG_FRAME_H: fh_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc && first_box_i) begin
        cur_left_q   <= RW'(fw_s);
        cur_top_q    <= RW'(fh_s);
        cur_width_q  <= RW'(fw_neg);
        cur_height_q <= RW'(fh_neg);
      end else if (out_load) begin
        cur_left_q   <= res_left;
        cur_top_q    <= res_top;
        cur_width_q  <= res_width;
        cur_height_q <= res_height;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      afra_pkg::ST_IDLE: begin
        if (in_acc) begin
          bx_q <= box_left_i;
          by_q <= box_top_i;
          bw_q <= box_width_i;
          bh_q <= box_height_i;
        end
      end
      afra_pkg::ST_UNION: begin
        ul_q <= (bx_e < cl_e) ? bx_e : cl_e;
        ut_q <= (by_e < ct_e) ? by_e : ct_e;
        ur_q <= (box_r > cur_r) ? box_r : cur_r;
        ub_q <= (box_b > cur_b) ? box_b : cur_b;
      end
      afra_pkg::ST_SPAN: begin
        u_q <= UW'(ur_q - ul_q);
        v_q <= UW'(ub_q - ut_q);
      end
      afra_pkg::ST_MUL_A: begin
        prod_a_q <= mul_p;
        c_q      <= ul_q + u_half;
      end
      afra_pkg::ST_MUL_B: prod_b_q <= mul_p;
      afra_pkg::ST_CLASS: begin
        fit_q <= fit_c;
        if (fit_c == afra_pkg::FIT_CAP) t_q <= t_cap;
      end
      afra_pkg::ST_DIV1: if (div_stat.done) t_q <= t_div;
      afra_pkg::ST_DIV2: begin
        if (div_stat.done) begin
          if (fit_q == afra_pkg::FIT_WIDE) begin
            nh_q <= {t_q, {QF{1'b0}}};
            nw_q <= div_quotient[QW-1:0];
          end else begin
            nw_q <= {t_q, {QF{1'b0}}};
            nh_q <= div_quotient[QW-1:0];
          end
        end
      end
      afra_pkg::ST_POS1: begin
        nx0_q <= NW'(x1_t);
        ny1_q <= NW'(z1_t);
      end
      afra_pkg::ST_POS2: begin
        // a negative left edge pins to zero and keeps the full width
        nx1_q <= NW'(y2_t);
        if (nx0_q[NW-1]) nx0_q <= '0;
        // bottom overshoot moves the top up; no clamp at zero
        if (ny1_q > fh_n) begin
          ny0_q <= ut_n - (ny1_q - fh_n);
          ny1_q <= fh_n;
        end else begin
          ny0_q <= ut_n;
        end
      end
      afra_pkg::ST_CLAMP: begin
        if (nx1_q > fw_n) begin
          nx0_q <= nx0_q - (nx1_q - fw_n);
          nx1_q <= fw_n;
        end
      end
      afra_pkg::ST_DONE: begin
        if (out_load) begin
          region_left_q   <= res_left;
          region_top_q    <= res_top;
          region_width_q  <= res_width;
          region_height_q <= res_height;
        end
      end
      default: ;
    endcase
  end

  afra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .stat_o     (div_stat)
  );

  assign out_valid_o     = out_valid_q;
  assign region_left_o   = region_left_q;
  assign region_top_o    = region_top_q;
  assign region_width_o  = region_width_q;
  assign region_height_o = region_height_q;

  logic in_idle, in_mul_t, div_wait;
  assign in_idle  = (state_q == afra_pkg::ST_IDLE);
  assign in_mul_t = (state_q == afra_pkg::ST_MUL_T);
  assign div_wait = (state_q == afra_pkg::ST_DIV1) || (state_q == afra_pkg::ST_DIV2);

  `ASSERT_NEXT(a_done_presents, clk_i, rst_ni, out_load, out_valid_q && in_idle, "no result shown")
  `ASSERT_IMPLIES(a_div_done_wait, clk_i, rst_ni, div_stat.done, div_wait, "stray divider result")
  `ASSERT_IMPLIES(a_div_busy_wait, clk_i, rst_ni, div_stat.busy, div_wait, "stray divider run")
  `ASSERT_IMPLIES(a_t_clipped, clk_i, rst_ni, in_mul_t, t_q <= t_lim, "side not clipped to frame")

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for auto_frame_region_accumulate_top: random valid/stall traffic
// on both channels, a built-in region predictor and in-order result checking.
// Depends on afra_pkg and the RTL of the region accumulator.
`timescale 1ns / 1ps

module tb;

  localparam int CB         = afra_pkg::COORD_BITS_DEF;
  localparam int DW         = afra_pkg::DIM_W;
  localparam int CYCLE_CAP  = 300000;
  localparam int HOLD_LEN   = 300;
  localparam int HOLD_AFTER = 200;

  typedef struct {
    logic signed [CB-1:0] left;
    logic signed [CB-1:0] top;
    logic [DW-1:0]        width;
    logic [DW-1:0]        height;
    logic                 restart;
  } box_t;

  typedef struct {
    logic [CB:0] left;
    logic [CB:0] top;
    logic [CB:0] width;
    logic [CB:0] height;
  } region_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [afra_pkg::CFG_IDX_W-1:0] cfg_idx_i = afra_pkg::REG_FRAME_W;
  logic [DW-1:0]              cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [CB-1:0]       box_left_i = '0;
  logic signed [CB-1:0]       box_top_i = '0;
  logic [DW-1:0]              box_width_i = '0;
  logic [DW-1:0]              box_height_i = '0;
  logic                       first_box_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [CB:0]         region_left_o;
  logic signed [CB:0]         region_top_o;
  logic signed [CB:0]         region_width_o;
  logic signed [CB:0]         region_height_o;

  auto_frame_region_accumulate_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .box_left_i      (box_left_i),
    .box_top_i       (box_top_i),
    .box_width_i     (box_width_i),
    .box_height_i    (box_height_i),
    .first_box_i     (first_box_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .region_left_o   (region_left_o),
    .region_top_o    (region_top_o),
    .region_width_o  (region_width_o),
    .region_height_o (region_height_o)
  );

  // predictor copy of the frame size and the running region
  longint frm_w = 640;
  longint frm_h = 480;
  longint reg_l = 640;
  longint reg_t = 480;
  longint reg_w = -640;
  longint reg_h = -480;

  box_t    box_queue[$];
  region_t region_queue[$];
  box_t    cur_box;
  int      n_queued = 0;
  int      n_accepted = 0;
  int      n_results = 0;
  int      n_errors = 0;
  int      n_settings = 1;
  int      idle_pct = 0;
  int      gap_cnt = 0;
  int      stall_cnt = 0;
  int      hold_cnt = 0;
  bit      hold_done = 1'b0;
  int      cycles = 0;

  function automatic longint wrap_coord(longint v);
    logic [CB:0] f;
    f = v[CB:0];
    return longint'($signed(f));
  endfunction

  function automatic longint safe_div(longint num, longint den);
    if (den == 0) return 0;
    return num / den;
  endfunction

  // union the box into the region, refit to the frame ratio, push back inside
  function automatic region_t merge_box(box_t b);
    longint bx, by, bw, bh, ul, ut, ur, ub, u, v, c, nw, nh, x0, x1, y0, y1, t, fw, fh;
    region_t r;
    fw = frm_w;
    fh = frm_h;
    bx = longint'($signed(b.left));
    by = longint'($signed(b.top));
    bw = longint'(b.width);
    bh = longint'(b.height);
    if (b.restart) begin
      reg_l = wrap_coord(fw);
      reg_t = wrap_coord(fh);
      reg_w = wrap_coord(-fw);
      reg_h = wrap_coord(-fh);
    end
    ul = (bx < reg_l) ? bx : reg_l;
    ut = (by < reg_t) ? by : reg_t;
    ur = reg_l + reg_w;
    if (bx + bw > ur) ur = bx + bw;
    ub = reg_t + reg_h;
    if (by + bh > ub) ub = by + bh;
    u = ur - ul;
    v = ub - ut;
    c = ul + u / 2;
    if (2 * v * fw > 5 * u * fh) begin
      t = (5 * u) / 2;
      if (t > fw) t = fw;
      nw = t * 256;
      nh = safe_div(t * fh * 256, fw);
    end else if (v * fw > u * fh) begin
      t = safe_div(v * fw, fh);
      if (t > fw) t = fw;
      nw = t * 256;
      nh = safe_div(t * fh * 256, fw);
    end else begin
      t = safe_div(u * fh, fw);
      if (t > fh) t = fh;
      nh = t * 256;
      nw = safe_div(t * fw * 256, fh);
    end
    x0 = (c * 512 - nw) / 512;
    if (x0 < 0) begin
      x1 = (c * 512 + nw - x0 * 512) / 512;
      x0 = 0;
    end else begin
      x1 = (c * 512 + nw) / 512;
    end
    if (x1 > fw) begin
      x0 -= x1 - fw;
      x1 = fw;
    end
    y0 = ut;
    y1 = (ut * 256 + nh) / 256;
    if (y1 > fh) begin
      y0 -= y1 - fh;
      y1 = fh;
    end
    reg_l = wrap_coord(x0);
    reg_t = wrap_coord(y0);
    reg_w = wrap_coord(x1 - x0);
    reg_h = wrap_coord(y1 - y0);
    r.left   = reg_l[CB:0];
    r.top    = reg_t[CB:0];
    r.width  = reg_w[CB:0];
    r.height = reg_h[CB:0];
    return r;
  endfunction

  function automatic box_t mk_box(int l, int t, int w, int h, bit rs);
    box_t b;
    b.left    = l[CB-1:0];
    b.top     = t[CB-1:0];
    b.width   = w[DW-1:0];
    b.height  = h[DW-1:0];
    b.restart = rs;
    return b;
  endfunction

  function automatic void queue_box(box_t b);
    box_queue.insert(box_queue.size(), b);
    n_queued++;
  endfunction

  // mostly plausible detections inside the frame, some raw noise
  function automatic box_t rand_box(bit rs);
    box_t b;
    int w, h;
    w = (frm_w > 0) ? int'(frm_w) : 1;
    h = (frm_h > 0) ? int'(frm_h) : 1;
    if ($urandom_range(9) < 8) begin
      b = mk_box($urandom_range(w - 1), $urandom_range(h - 1),
                 $urandom_range((w + 1) / 2), $urandom_range((h + 1) / 2), rs);
    end else begin
      b = mk_box($urandom, $urandom, $urandom, $urandom, $urandom_range(1));
    end
    return b;
  endfunction

  task automatic queue_frames(int n_items);
    int n_boxes;
    while (n_items > 0) begin
      n_boxes = $urandom_range(1, 6);
      for (int k = 0; k < n_boxes && n_items > 0; k++) begin
        // one frame in ten loses its restart marker
        queue_box(rand_box(k == 0 && $urandom_range(9) != 0));
        n_items--;
      end
    end
  endtask

  task automatic wait_idle();
    while (!(n_accepted == n_queued && region_queue.size() == 0)) @(posedge clk_i);
  endtask

  task automatic write_frame(int w, int h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= afra_pkg::REG_FRAME_W;
    cfg_data_i <= w[DW-1:0];
    frm_w = w;
    @(posedge clk_i);
    cfg_idx_i  <= afra_pkg::REG_FRAME_H;
    cfg_data_i <= h[DW-1:0];
    frm_h = h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic check_field(string what, logic [CB:0] want, logic [CB:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t ERROR %s: expected %0d, got %0d", $time, what,
               $signed(want), $signed(got));
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               region_queue.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // box sender
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        region_queue.insert(region_queue.size(), merge_box(cur_box));
        n_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
          gap_cnt = $urandom_range(1, 11) - 1;
        end else if (box_queue.size() > 0) begin
          cur_box = box_queue.pop_front();
          nxt_valid = 1'b1;
          box_left_i   <= cur_box.left;
          box_top_i    <= cur_box.top;
          box_width_i  <= cur_box.width;
          box_height_i <= cur_box.height;
          first_box_i  <= cur_box.restart;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // region receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    region_t want;
    logic nxt_stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (region_queue.size() == 0) begin
          n_errors++;
          $display("%0t ERROR region transfer with nothing expected", $time);
        end else begin
          want = region_queue.pop_front();
          check_field("region_left", want.left, region_left_o);
          check_field("region_top", want.top, region_top_o);
          check_field("region_width", want.width, region_width_o);
          check_field("region_height", want.height, region_height_o);
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!hold_done && n_results >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        nxt_stall = 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        nxt_stall = 1'b1;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        stall_cnt = $urandom_range(1, 11) - 1;
        nxt_stall = 1'b1;
      end else begin
        nxt_stall = 1'b0;
      end
      out_stall_i <= nxt_stall;
    end
  end

  initial begin
    int cfg_w[6];
    int cfg_h[6];
    cfg_w = '{4095, 1, 1, 4095, 0, 640};
    cfg_h = '{4095, 1, 4095, 1, 480, 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed boxes at the reset frame size
    idle_pct = 20;
    queue_box(mk_box(100, 100, 20, 300, 1'b0));   // no restart: merges into reset region
    queue_box(mk_box(100, 100, 20, 300, 1'b1));   // too tall: width capped
    queue_box(mk_box(300, 100, 100, 120, 1'b1));  // tall: width grown
    queue_box(mk_box(100, 100, 300, 100, 1'b1));  // wide: height grown
    queue_box(mk_box(0, 0, 0, 0, 1'b1));
    queue_box(mk_box(-4096, -4096, 4095, 4095, 1'b1));
    queue_box(mk_box(4095, 4095, 4095, 4095, 1'b1));
    queue_box(mk_box(4095, -4096, 0, 4095, 1'b0));
    queue_box(mk_box(-4096, 4095, 4095, 0, 1'b0));
    queue_box(mk_box(10, 10, 50, 40, 1'b1));      // tall: width grown near the left edge
    queue_box(mk_box(620, 200, 15, 10, 1'b1));    // wide: height grown near the right edge
    queue_box(mk_box(300, 470, 30, 100, 1'b1));   // overshoots bottom edge
    queue_box(mk_box(-50, -100, 30, 20, 1'b1));   // top above frame
    queue_box(mk_box(200, 150, 40, 30, 1'b0));
    queue_box(mk_box(250, 180, 60, 50, 1'b0));
    queue_box(mk_box(100, 300, 10, 10, 1'b0));
    queue_box(mk_box(0, 0, 640, 480, 1'b1));
    queue_box(mk_box(5, 5, 630, 2, 1'b1));
    queue_box(mk_box(319, 0, 2, 480, 1'b1));
    queue_box(mk_box(-1, -1, 4095, 1, 1'b0));

    // extreme and degenerate frame sizes, zero dimensions among them
    for (int s = 0; s < 6; s++) begin
      wait_idle();
      write_frame(cfg_w[s], cfg_h[s]);
      idle_pct = (s % 2 == 0) ? 0 : 30;
      queue_box(mk_box(0, 0, 4095, 4095, 1'b1));
      queue_box(mk_box(-4096, 4095, 0, 0, 1'b0));
      queue_frames(10);
    end

    // random frame sizes with frames of random boxes
    for (int s = 0; s < 6; s++) begin
      wait_idle();
      write_frame($urandom_range(1, 4095), $urandom_range(1, 4095));
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      queue_frames(50);
    end

    // closing part at the reset size, no idling on either side
    idle_pct = 0;
    wait_idle();
    write_frame(640, 480);
    queue_frames(40);

    wait_idle();
    repeat (60) @(posedge clk_i);
    $display("summary: %0d boxes over %0d frame sizes, %0d regions checked, %0d mismatches",
             n_accepted, n_settings, n_results, n_errors);
    if (n_errors == 0 && region_queue.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
